// File: rtl/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg
// shared types and constants for the half/single float converter
// ----------------------------------------------------------------------------
package hfc_pkg;

    localparam int unsigned DataWidth = 32;

    typedef enum logic
    {
        OP_TO_HALF   = 1'b0,
        OP_TO_SINGLE = 1'b1
    } op_t;

    localparam logic [30:0] AbsInfNan   = 31'h7F800000;
    localparam logic [30:0] AbsOverflow = 31'h477FF000;
    localparam logic [30:0] AbsMinNorm  = 31'h38800000;
    localparam logic [30:0] AbsTiny     = 31'h33000000;
    localparam logic [30:0] BiasAdjust  = 31'h38000000;
    localparam logic [15:0] HalfInf     = 16'h7C00;
    localparam logic [15:0] HalfQuiet   = 16'h0200;

    // classification of a conversion in either direction
    typedef enum logic [2:0]
    {
        CLS_NAN,
        CLS_INF,
        CLS_NORM,
        CLS_ZERO,
        CLS_SUB,
        CLS_HALF_ZERO,
        CLS_HALF_SUB,
        CLS_HALF_FULL
    } cls_t;

endpackage

// File: rtl/half_float_converter_top.sv
// ----------------------------------------------------------------------------
// half_float_converter_top
// streaming converter between ieee binary32 and binary16
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The datapath is a three
// stage pipeline (classify, shift/normalize, round/pack) with a valid bit per
// stage, so one conversion per clock is sustained while m_axis_tready stays
// high. m_axis_tvalid rises once an accepted transaction has moved through
// the stage 1 and stage 2 registers into the stage 3 register. Back pressure
// on m_axis stalls only the stages that hold data; bubbles are squeezed out,
// and s_axis_tready stays high while the pipeline has a free slot.
// s_axis_tuser selects the direction: 0 converts single to half (round to
// nearest even), 1 converts the low 16 bits as a half to single (exact).
module half_float_converter_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hfc_pkg::DataWidth-1:0] s_axis_tdata,  // value_bits
    input  logic                          s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hfc_pkg::DataWidth-1:0] m_axis_tdata   // result_bits
);
    import hfc_pkg::*;

    // stage enables: a stage advances when its successor is free
    logic en3, en2, en1;
    logic v1_reg, v2_reg, v3_reg;

    assign en3 = ~v3_reg | m_axis_tready;
    assign en2 = ~v2_reg | en3;
    assign en1 = ~v1_reg | en2;
    assign s_axis_tready = en1;

    // ---------------- stage 1: classify ----------------
    logic        sign1_reg;
    logic [30:0] ax1_reg;
    cls_t        cls1_reg;
    cls_t        cls1_next;
    logic [15:0] h_in;

    assign h_in = s_axis_tdata[15:0];

    always_comb
    begin
        logic [30:0] ax;
        ax = s_axis_tdata[30:0];
        if (s_axis_tuser == OP_TO_SINGLE)
        begin
            if (h_in[14:10] == 5'd0)
                cls1_next = (h_in[9:0] == 10'd0) ? CLS_HALF_ZERO : CLS_HALF_SUB;
            else
                cls1_next = CLS_HALF_FULL;
        end
        else if (ax > AbsInfNan)
            cls1_next = CLS_NAN;
        else if (ax >= AbsOverflow)
            cls1_next = CLS_INF;
        else if (ax >= AbsMinNorm)
            cls1_next = CLS_NORM;
        else if (ax <= AbsTiny)
            cls1_next = CLS_ZERO;
        else
            cls1_next = CLS_SUB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            sign1_reg <= (s_axis_tuser == OP_TO_SINGLE) ? h_in[15] : s_axis_tdata[31];
            ax1_reg   <= (s_axis_tuser == OP_TO_SINGLE) ? {16'd0, h_in[14:0]}
                                                        : s_axis_tdata[30:0];
            cls1_reg  <= cls1_next;
        end
    end

    // ---------------- stage 2: shift / normalize ----------------
    logic        sign2_reg;
    cls_t        cls2_reg;
    logic [30:0] w2_reg;       // biased value, shifted mantissa or normalized
    logic [4:0]  lz2_reg;      // half subnormal leading position
    logic        rnd2_reg;     // round increment for subnormal half
    logic [30:0] w2_next;
    logic [4:0]  lz2_next;
    logic        rnd2_next;

    always_comb
    begin
        logic [23:0] m;
        logic [4:0]  sh;
        logic [23:0] rem;
        logic [23:0] hv;
        logic [9:0]  hm;
        logic [3:0]  p;
        w2_next   = ax1_reg;
        lz2_next  = 5'd0;
        rnd2_next = 1'b0;
        m   = {1'b1, ax1_reg[22:0]};
        sh  = 5'(8'd126 - ax1_reg[30:23]);
        hv  = m >> sh;
        rem = m & ((24'd1 << sh) - 24'd1);
        hm  = ax1_reg[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++)
            if (hm[i])
                p = 4'(i);
        unique case (cls1_reg)
            CLS_NORM:
                w2_next = ax1_reg - BiasAdjust + 31'h0FFF + 31'(ax1_reg[13]);
            CLS_SUB:
            begin
                w2_next   = 31'(hv);
                rnd2_next = (rem > (24'd1 << (sh - 5'd1)))
                         || ((rem == (24'd1 << (sh - 5'd1))) && hv[0]);
            end
            CLS_HALF_SUB:
            begin
                lz2_next = 5'(p);
                w2_next  = 31'({hm, 13'd0} << (5'd10 - 5'(p)));
            end
            default:
                w2_next = ax1_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            sign2_reg <= sign1_reg;
            cls2_reg  <= cls1_reg;
            w2_reg    <= w2_next;
            lz2_reg   <= lz2_next;
            rnd2_reg  <= rnd2_next;
        end
    end

    // ---------------- stage 3: round / pack ----------------
    logic [31:0] res3_reg;
    logic [31:0] res3_next;

    always_comb
    begin
        logic [15:0] hs;
        hs = {sign2_reg, 15'd0};
        unique case (cls2_reg)
            CLS_NAN:
                res3_next = {16'd0, hs | HalfInf | HalfQuiet | {6'd0, w2_reg[22:13]}};
            CLS_INF:
                res3_next = {16'd0, hs | HalfInf};
            CLS_NORM:
                res3_next = {16'd0, hs | 16'(w2_reg[30:13])};
            CLS_ZERO:
                res3_next = {16'd0, hs};
            CLS_SUB:
                res3_next = {16'd0, hs | 16'(w2_reg[10:0] + 11'(rnd2_reg))};
            CLS_HALF_ZERO:
                res3_next = {sign2_reg, 31'd0};
            CLS_HALF_SUB:
                res3_next = {sign2_reg, 8'(lz2_reg + 5'd0) + 8'd103, w2_reg[22:0]};
            CLS_HALF_FULL:
                res3_next = (w2_reg[14:10] == 5'h1F)
                          ? {sign2_reg, 8'hFF, w2_reg[9:0], 13'd0}
                          : {sign2_reg, 8'(w2_reg[14:10]) + 8'd112, w2_reg[9:0], 13'd0};
            default:
                res3_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
            res3_reg <= res3_next;
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = res3_reg;

endmodule

// File: rtl/hfc_checker.sv
// ----------------------------------------------------------------------------
// hfc_checker
// port level checks for the converter
// ----------------------------------------------------------------------------
module hfc_port_checks
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import hfc_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

    // a result follows an accepted input while m_axis_tready stays high
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("pipeline lost a transaction");

    // half results keep the upper word clear
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TO_HALF
        && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tdata[31:16] == 16'd0)
        else $error("half result has upper bits set");

    // a free output always accepts input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked without back pressure");

endmodule

bind half_float_converter_top hfc_port_checks u_hfc_port_checks
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
